FILE: src/pls_pkg.sv
package pls_pkg;

  localparam int OP_W = 4;

  localparam logic [OP_W-1:0] OP_TTL       = 4'd0;
  localparam logic [OP_W-1:0] OP_CLOCK     = 4'd1;
  localparam logic [OP_W-1:0] OP_DAC       = 4'd2;
  localparam logic [OP_W-1:0] OP_WAIT      = 4'd3;
  localparam logic [OP_W-1:0] OP_CLEAR_ERR = 4'd4;
  localparam logic [OP_W-1:0] OP_SET_FREQ  = 4'd5;
  localparam logic [OP_W-1:0] OP_SET_AMP   = 4'd6;
  localparam logic [OP_W-1:0] OP_SET_PHASE = 4'd7;
  localparam logic [OP_W-1:0] OP_DDS_RESET = 4'd8;
  localparam logic [OP_W-1:0] OP_LOOPBACK  = 4'd9;
  localparam logic [OP_W-1:0] OP_GET_FREQ  = 4'd10;
  localparam logic [OP_W-1:0] OP_GET_AMP   = 4'd11;
  localparam logic [OP_W-1:0] OP_GET_PHASE = 4'd12;
  localparam logic [OP_W-1:0] OP_LAST      = OP_GET_PHASE;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_OP   = 2'd1,
    ERR_CHAN = 2'd2
  } err_t;

  localparam int NUM_CFG   = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DDS_FREQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DDS_AMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DDS_PHASE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DDS_RESET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPBACK  = 3'd7;

  // Reset values, highest register index first.
  localparam logic [NUM_CFG-1:0][CFG_W-1:0] CFG_RESET = {
    10'd5, 10'd50, 10'd50, 10'd50, 10'd50, 10'd5, 10'd45, 10'd5
  };

  // x / 10 == (x * 0xCCCCCCCD) >> 35 for every 32-bit x.
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;
  localparam int          GAPQ_W      = 29;

  localparam int FREQ_W  = 32;
  localparam int AMP_W   = 16;
  localparam int PHASE_W = 16;
  localparam int DDS_WORD_W = FREQ_W + AMP_W + PHASE_W;

  typedef struct packed {
    err_t              err;
    logic [OP_W-1:0]   op;
    logic              timing;
    logic [31:0]       va;
    logic [31:0]       vb;
    logic              gap_nz;
    logic [GAPQ_W-1:0] gap_q;
  } cmd_t;

  typedef struct packed {
    err_t        error;
    logic        rb_valid;
    logic [31:0] rb_value;
    logic [31:0] duration;
    logic [31:0] ttl;
    logic [7:0]  clk_div;
    logic        timing_ok;
    logic [31:0] count;
    logic [31:0] cycles;
    logic [31:0] underflow;
  } res_t;

  function automatic logic is_dds(input logic [OP_W-1:0] op);
    return (op == OP_SET_FREQ) || (op == OP_SET_AMP) || (op == OP_SET_PHASE) ||
           (op == OP_DDS_RESET) || (op == OP_GET_FREQ) || (op == OP_GET_AMP) ||
           (op == OP_GET_PHASE);
  endfunction

endpackage

FILE: src/pls_ram.sv
module pls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/pls_fifo.sv
module pls_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue fill count did not grow on a lone push");

endmodule

FILE: src/pls_front.sv
module pls_front #(
  parameter int DDS_CHANNELS = 32
) (
  input  logic [pls_pkg::OP_W-1:0] operation,
  input  logic                     timing,
  input  logic [31:0]              value_a,
  input  logic [31:0]              value_b,
  input  logic [31:0]              gap_ns,
  output pls_pkg::cmd_t            cmd
);

  logic [63:0] gap_prod;

  // Divide the lateness by ten with a reciprocal multiply.
  assign gap_prod = 64'(gap_ns) * 64'(pls_pkg::DIV10_MUL);

  always_comb begin
    cmd.op     = operation;
    cmd.timing = timing;
    cmd.va     = value_a;
    cmd.vb     = value_b;
    cmd.gap_nz = (gap_ns != '0);
    cmd.gap_q  = gap_prod[pls_pkg::DIV10_SHIFT +: pls_pkg::GAPQ_W];
    if (operation > pls_pkg::OP_LAST) begin
      cmd.err = pls_pkg::ERR_OP;
    end else if (pls_pkg::is_dds(operation) && (value_a >= 32'(DDS_CHANNELS))) begin
      cmd.err = pls_pkg::ERR_CHAN;
    end else begin
      cmd.err = pls_pkg::ERR_OK;
    end
  end

endmodule

FILE: src/pls_back.sv
module pls_back #(
  parameter int DDS_CHANNELS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pls_pkg::CFG_W-1:0]     cfg_data,
  input  pls_pkg::cmd_t                 cmd_head,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  output pls_pkg::res_t                 res,
  output logic                          res_push,
  input  logic                          res_full
);

  localparam int CH_W = (DDS_CHANNELS > 1) ? $clog2(DDS_CHANNELS) : 1;
  localparam int WW   = pls_pkg::DDS_WORD_W;

  logic [pls_pkg::NUM_CFG-1:0][pls_pkg::CFG_W-1:0] cfg_r;

  logic          b_vld_r;
  pls_pkg::cmd_t b_q_r;
  logic          b_go;
  logic [CH_W-1:0] b_chan;

  logic [DDS_CHANNELS-1:0] ch_vld_r;
  logic            byp_vld_r;
  logic [CH_W-1:0] byp_addr_r;
  logic [WW-1:0]   byp_word_r;
  logic [WW-1:0]   ram_rdata, cur_word, wr_word;
  logic            dds_wr;

  logic [31:0] ttl_r, ttl_nxt;
  logic [7:0]  div_r, div_nxt;
  logic        pend_r, pend_nxt;
  logic        tg_r, tg_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] cyc_r, cyc_nxt;
  logic [31:0] uf_r, uf_nxt;
  logic [31:0] dur;
  logic        rb_v;
  logic [31:0] rb;

  assign b_go    = b_vld_r && !res_full;
  assign cmd_pop = !cmd_empty && (!b_vld_r || b_go);
  assign b_chan  = b_q_r.va[CH_W-1:0];

  pls_ram #(
    .WIDTH (WW),
    .DEPTH (DDS_CHANNELS)
  ) u_dds_ram (
    .clk   (clk),
    .we    (b_go && dds_wr),
    .waddr (b_chan),
    .wdata (wr_word),
    .re    (cmd_pop),
    .raddr (cmd_head.va[CH_W-1:0]),
    .rdata (ram_rdata)
  );

  // The RAM read happens as the command loads, so the write of the command
  // just ahead of it is taken from the bypass register instead.
  always_comb begin
    if (byp_vld_r && (byp_addr_r == b_chan)) begin
      cur_word = byp_word_r;
    end else if (ch_vld_r[b_chan]) begin
      cur_word = ram_rdata;
    end else begin
      cur_word = '0;
    end
  end

  always_comb begin
    ttl_nxt  = ttl_r;
    div_nxt  = div_r;
    pend_nxt = pend_r;
    tg_nxt   = tg_r;
    cnt_nxt  = cnt_r;
    cyc_nxt  = cyc_r;
    uf_nxt   = uf_r;
    dur      = '0;
    rb_v     = 1'b0;
    rb       = '0;
    dds_wr   = 1'b0;
    wr_word  = cur_word;
    if (b_q_r.err == pls_pkg::ERR_OK) begin
      if (pend_r && b_q_r.gap_nz) begin
        tg_nxt = 1'b0;
        uf_nxt = uf_r + 32'(b_q_r.gap_q) + 32'd1;
      end
      pend_nxt = b_q_r.timing;
      unique case (b_q_r.op)
        pls_pkg::OP_TTL: begin
          ttl_nxt = b_q_r.vb;
          dur     = b_q_r.va;
        end
        pls_pkg::OP_CLOCK: begin
          div_nxt = b_q_r.va[7:0];
          dur     = 32'(cfg_r[pls_pkg::CFG_CLOCK]);
        end
        pls_pkg::OP_DAC: dur = 32'(cfg_r[pls_pkg::CFG_DAC]);
        pls_pkg::OP_WAIT: dur = b_q_r.va;
        pls_pkg::OP_CLEAR_ERR: begin
          tg_nxt = 1'b1;
          uf_nxt = '0;
          dur    = 32'(cfg_r[pls_pkg::CFG_CLEAR]);
        end
        pls_pkg::OP_SET_FREQ: begin
          dds_wr = 1'b1;
          wr_word[WW-1 -: pls_pkg::FREQ_W] = b_q_r.vb;
          dur = 32'(cfg_r[pls_pkg::CFG_DDS_FREQ]);
        end
        pls_pkg::OP_SET_AMP: begin
          dds_wr = 1'b1;
          wr_word[pls_pkg::PHASE_W +: pls_pkg::AMP_W] = b_q_r.vb[pls_pkg::AMP_W-1:0];
          dur = 32'(cfg_r[pls_pkg::CFG_DDS_AMP]);
        end
        pls_pkg::OP_SET_PHASE: begin
          dds_wr = 1'b1;
          wr_word[pls_pkg::PHASE_W-1:0] = b_q_r.vb[pls_pkg::PHASE_W-1:0];
          dur = 32'(cfg_r[pls_pkg::CFG_DDS_PHASE]);
        end
        pls_pkg::OP_DDS_RESET: begin
          dds_wr  = 1'b1;
          wr_word = '0;
          dur     = 32'(cfg_r[pls_pkg::CFG_DDS_RESET]);
        end
        pls_pkg::OP_LOOPBACK: begin
          rb_v = 1'b1;
          rb   = b_q_r.va;
          dur  = 32'(cfg_r[pls_pkg::CFG_LOOPBACK]);
        end
        pls_pkg::OP_GET_FREQ: begin
          rb_v = 1'b1;
          rb   = cur_word[WW-1 -: pls_pkg::FREQ_W];
          dur  = 32'(cfg_r[pls_pkg::CFG_DDS_FREQ]);
        end
        pls_pkg::OP_GET_AMP: begin
          rb_v = 1'b1;
          rb   = 32'(cur_word[pls_pkg::PHASE_W +: pls_pkg::AMP_W]);
          dur  = 32'(cfg_r[pls_pkg::CFG_DDS_AMP]);
        end
        default: begin
          rb_v = 1'b1;
          rb   = 32'(cur_word[pls_pkg::PHASE_W-1:0]);
          dur  = 32'(cfg_r[pls_pkg::CFG_DDS_PHASE]);
        end
      endcase
      cnt_nxt = cnt_r + 32'd1;
      cyc_nxt = cyc_r + dur;
    end
  end

  assign res_push = b_go;

  always_comb begin
    res.error     = b_q_r.err;
    res.rb_valid  = rb_v;
    res.rb_value  = rb;
    res.duration  = dur;
    res.ttl       = ttl_nxt;
    res.clk_div   = div_nxt;
    res.timing_ok = tg_nxt;
    res.count     = cnt_nxt;
    res.cycles    = cyc_nxt;
    res.underflow = uf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= pls_pkg::CFG_RESET;
      b_vld_r   <= 1'b0;
      ch_vld_r  <= '0;
      byp_vld_r <= 1'b0;
      ttl_r     <= '0;
      div_r     <= '0;
      pend_r    <= 1'b0;
      tg_r      <= 1'b1;
      cnt_r     <= '0;
      cyc_r     <= '0;
      uf_r      <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      if (cmd_pop) begin
        b_vld_r <= 1'b1;
      end else if (b_go) begin
        b_vld_r <= 1'b0;
      end
      if (b_go) begin
        byp_vld_r <= dds_wr;
        if (dds_wr) begin
          ch_vld_r[b_chan] <= 1'b1;
        end
        ttl_r  <= ttl_nxt;
        div_r  <= div_nxt;
        pend_r <= pend_nxt;
        tg_r   <= tg_nxt;
        cnt_r  <= cnt_nxt;
        cyc_r  <= cyc_nxt;
        uf_r   <= uf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      b_q_r <= cmd_head;
    end
    if (b_go) begin
      byp_addr_r <= b_chan;
      byp_word_r <= wr_word;
    end
  end

  a_err_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (b_go && (b_q_r.err != pls_pkg::ERR_OK)) |=> (cnt_r == $past(cnt_r)))
    else $error("rejected command changed the executed count");

  a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
    (b_go && (b_q_r.err == pls_pkg::ERR_OK)) |=> (cnt_r == $past(cnt_r) + 32'd1))
    else $error("executed command was not counted");

  a_tg_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(tg_r) |-> $past(b_go && pend_r && b_q_r.gap_nz))
    else $error("timing_ok dropped without an underflow");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !b_go |=> ($stable(uf_r) && $stable(cyc_r) && $stable(pend_r)))
    else $error("status changed without a command commit");

endmodule

FILE: src/pulse_sequencer_command_executor_core.sv
// Pulse-sequencer command executor.
//
// Commands enter through a queue-style port: a command is transferred on a
// clock edge with push high and full low. Results leave the same way: while
// empty is low the oldest result sits on the out_ ports, and it is transferred
// on an edge with pop high. The user must write duration registers (cfg_we,
// cfg_index, cfg_data) only while no command is in flight; it is not checked.
//
// Each command gives one result. A command passes the command queue, the
// back-end command register and the result queue; one command per cycle is
// sustained while the result queue is not full. The front end decodes, checks
// and divides the lateness by ten in the same cycle; the back end executes one
// command per cycle unless stalled, using one DDS RAM read and one write port.
//
// The back end stalls when the two-entry result queue is full, and the
// two-entry command queue then fills and raises full. Reset clears all status
// and restores the duration registers; the DDS store reads as zero per
// channel until written, so no clearing pass is needed after reset.
module pulse_sequencer_command_executor_core #(
  parameter int DDS_CHANNELS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [pls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pls_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [pls_pkg::OP_W-1:0]      in_operation,
  input  logic                          in_timing,
  input  logic [31:0]                   in_value_a,
  input  logic [31:0]                   in_value_b,
  input  logic [31:0]                   in_gap_ns,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_error,
  output logic                          out_readback_valid,
  output logic [31:0]                   out_readback_value,
  output logic [31:0]                   out_duration_cycles,
  output logic [31:0]                   out_ttl_state,
  output logic [7:0]                    out_clock_divider,
  output logic                          out_timing_ok,
  output logic [31:0]                   out_instruction_count,
  output logic [31:0]                   out_instruction_cycles,
  output logic [31:0]                   out_underflow_cycles
);

  localparam int CMD_W = $bits(pls_pkg::cmd_t);
  localparam int RES_W = $bits(pls_pkg::res_t);

  pls_pkg::cmd_t    front_cmd;
  logic [CMD_W-1:0] cmdq_rdata;
  logic             cmdq_empty, cmdq_pop;
  pls_pkg::res_t    back_res, res_head;
  logic [RES_W-1:0] resq_rdata;
  logic             res_push, resq_full;

  pls_front #(
    .DDS_CHANNELS (DDS_CHANNELS)
  ) u_front (
    .operation (in_operation),
    .timing    (in_timing),
    .value_a   (in_value_a),
    .value_b   (in_value_b),
    .gap_ns    (in_gap_ns),
    .cmd       (front_cmd)
  );

  pls_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (cmdq_pop),
    .rdata (cmdq_rdata),
    .empty (cmdq_empty)
  );

  pls_back #(
    .DDS_CHANNELS (DDS_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_head  (pls_pkg::cmd_t'(cmdq_rdata)),
    .cmd_empty (cmdq_empty),
    .cmd_pop   (cmdq_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (resq_full)
  );

  pls_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (resq_full),
    .pop   (pop),
    .rdata (resq_rdata),
    .empty (empty)
  );

  assign res_head               = pls_pkg::res_t'(resq_rdata);
  assign out_error              = res_head.error;
  assign out_readback_valid     = res_head.rb_valid;
  assign out_readback_value     = res_head.rb_value;
  assign out_duration_cycles    = res_head.duration;
  assign out_ttl_state          = res_head.ttl;
  assign out_clock_divider      = res_head.clk_div;
  assign out_timing_ok          = res_head.timing_ok;
  assign out_instruction_count  = res_head.count;
  assign out_instruction_cycles = res_head.cycles;
  assign out_underflow_cycles   = res_head.underflow;

endmodule

FILE: bench/tb_pulse_sequencer_command_executor_core.sv
`timescale 1ns / 1ps

module tb_pulse_sequencer_command_executor_core;

  localparam int DDS_CH       = 32;
  localparam int NS_PER_CYCLE = 10;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 215;
  localparam int OPW          = pls_pkg::OP_W;
  localparam int CFGW         = pls_pkg::CFG_W;
  localparam int IDXW         = pls_pkg::CFG_IDX_W;
  localparam int NCFG         = pls_pkg::NUM_CFG;
  localparam logic [OPW-1:0] OP_TOP       = {OPW{1'b1}};
  localparam logic [OPW-1:0] OP_FIRST_BAD = pls_pkg::OP_LAST + OPW'(1);

  typedef struct packed {
    logic [OPW-1:0]  op;
    logic            timing;
    logic [31:0]     va;
    logic [31:0]     vb;
    logic [31:0]     gap;
  } sequencer_cmd_t;

  // Tracks the executor's state and holds the status words still owed by the block.
  class sequencer_scoreboard;
    logic [CFGW-1:0]  durations [NCFG];
    logic [31:0]      freq_table [DDS_CH];
    logic [15:0]      amp_table [DDS_CH];
    logic [15:0]      phase_table [DDS_CH];
    logic [31:0]      ttl_word;
    logic [7:0]       clk_div;
    bit               check_armed;
    bit               timing_good;
    logic [31:0]      exec_count;
    logic [31:0]      cycle_sum;
    logic [31:0]      underflow_sum;
    pls_pkg::res_t    expected_status[$];
    int               errors;
    int               printed;

    function new();
      durations = '{10'd5, 10'd45, 10'd5, 10'd50, 10'd50, 10'd50, 10'd50, 10'd5};
      foreach (freq_table[i]) begin
        freq_table[i] = '0;
        amp_table[i] = '0;
        phase_table[i] = '0;
      end
      ttl_word = '0;
      clk_div = '0;
      check_armed = 1'b0;
      timing_good = 1'b1;
      exec_count = '0;
      cycle_sum = '0;
      underflow_sum = '0;
      errors = 0;
      printed = 0;
    endfunction

    static function bit dds_op(input logic [OPW-1:0] op);
      return op inside {[pls_pkg::OP_SET_FREQ:pls_pkg::OP_DDS_RESET],
                        [pls_pkg::OP_GET_FREQ:pls_pkg::OP_GET_PHASE]};
    endfunction

    function void set_duration(input logic [IDXW-1:0] idx, input logic [CFGW-1:0] val);
      durations[idx] = val;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    task report(input string msg);
      errors++;
      if (printed < 100) begin
        printed++;
        $display("%0t ns: %s", $time, msg);
      end
    endtask

    function void note_command(input sequencer_cmd_t c);
      pls_pkg::res_t r;
      logic [31:0] dur;
      int ch;
      r = '0;
      r.error = pls_pkg::ERR_OK;
      dur = '0;
      ch = c.va;
      if (c.op > pls_pkg::OP_LAST) r.error = pls_pkg::ERR_OP;
      else if (dds_op(c.op) && c.va >= DDS_CH) r.error = pls_pkg::ERR_CHAN;

      // Rejected commands leave every piece of state alone, the armed check included.
      if (r.error == pls_pkg::ERR_OK) begin
        if (check_armed && c.gap != 0) begin
          timing_good = 1'b0;
          underflow_sum += c.gap / NS_PER_CYCLE + 1;
        end
        check_armed = c.timing;
        unique case (c.op)
          pls_pkg::OP_TTL: begin
            ttl_word = c.vb;
            dur = c.va;
          end
          pls_pkg::OP_CLOCK: begin
            clk_div = c.va[7:0];
            dur = 32'(durations[pls_pkg::CFG_CLOCK]);
          end
          pls_pkg::OP_DAC: dur = 32'(durations[pls_pkg::CFG_DAC]);
          pls_pkg::OP_WAIT: dur = c.va;
          pls_pkg::OP_CLEAR_ERR: begin
            timing_good = 1'b1;
            underflow_sum = '0;
            dur = 32'(durations[pls_pkg::CFG_CLEAR]);
          end
          pls_pkg::OP_SET_FREQ: begin
            freq_table[ch] = c.vb;
            dur = 32'(durations[pls_pkg::CFG_DDS_FREQ]);
          end
          pls_pkg::OP_SET_AMP: begin
            amp_table[ch] = c.vb[15:0];
            dur = 32'(durations[pls_pkg::CFG_DDS_AMP]);
          end
          pls_pkg::OP_SET_PHASE: begin
            phase_table[ch] = c.vb[15:0];
            dur = 32'(durations[pls_pkg::CFG_DDS_PHASE]);
          end
          pls_pkg::OP_DDS_RESET: begin
            freq_table[ch] = '0;
            amp_table[ch] = '0;
            phase_table[ch] = '0;
            dur = 32'(durations[pls_pkg::CFG_DDS_RESET]);
          end
          pls_pkg::OP_LOOPBACK: begin
            r.rb_valid = 1'b1;
            r.rb_value = c.va;
            dur = 32'(durations[pls_pkg::CFG_LOOPBACK]);
          end
          pls_pkg::OP_GET_FREQ: begin
            r.rb_valid = 1'b1;
            r.rb_value = freq_table[ch];
            dur = 32'(durations[pls_pkg::CFG_DDS_FREQ]);
          end
          pls_pkg::OP_GET_AMP: begin
            r.rb_valid = 1'b1;
            r.rb_value = {16'd0, amp_table[ch]};
            dur = 32'(durations[pls_pkg::CFG_DDS_AMP]);
          end
          default: begin
            r.rb_valid = 1'b1;
            r.rb_value = {16'd0, phase_table[ch]};
            dur = 32'(durations[pls_pkg::CFG_DDS_PHASE]);
          end
        endcase
        exec_count += 1;
        cycle_sum += dur;
      end
      r.duration = dur;
      r.ttl = ttl_word;
      r.clk_div = clk_div;
      r.timing_ok = timing_good;
      r.count = exec_count;
      r.cycles = cycle_sum;
      r.underflow = underflow_sum;
      expected_status.push_back(r);
    endfunction

    task compare_field(input string name, input logic [31:0] got,
                       input logic [31:0] want);
      if (got !== want)
        report($sformatf("%s mismatch: got %h, expected %h", name, got, want));
    endtask

    task check_result(input pls_pkg::res_t got);
      pls_pkg::res_t want;
      if (expected_status.size() == 0) begin
        report("result transfer with no command outstanding");
        return;
      end
      want = expected_status.pop_front();
      compare_field("error", 32'(got.error), 32'(want.error));
      compare_field("readback_valid", 32'(got.rb_valid), 32'(want.rb_valid));
      compare_field("readback_value", got.rb_value, want.rb_value);
      compare_field("duration_cycles", got.duration, want.duration);
      compare_field("ttl_state", got.ttl, want.ttl);
      compare_field("clock_divider", 32'(got.clk_div), 32'(want.clk_div));
      compare_field("timing_ok", 32'(got.timing_ok), 32'(want.timing_ok));
      compare_field("instruction_count", got.count, want.count);
      compare_field("instruction_cycles", got.cycles, want.cycles);
      compare_field("underflow_cycles", got.underflow, want.underflow);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [IDXW-1:0]      cfg_index = '0;
  logic [CFGW-1:0]      cfg_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [OPW-1:0]       in_operation = '0;
  logic                 in_timing = 1'b0;
  logic [31:0]          in_value_a = '0;
  logic [31:0]          in_value_b = '0;
  logic [31:0]          in_gap_ns = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [1:0]           out_error;
  logic                 out_readback_valid;
  logic [31:0]          out_readback_value;
  logic [31:0]          out_duration_cycles;
  logic [31:0]          out_ttl_state;
  logic [7:0]           out_clock_divider;
  logic                 out_timing_ok;
  logic [31:0]          out_instruction_count;
  logic [31:0]          out_instruction_cycles;
  logic [31:0]          out_underflow_cycles;

  sequencer_scoreboard sb = new();
  bit quiet = 1'b0;
  int in_idle_pct = 20;
  int out_stall_pct = 20;
  int stall_left = 0;

  pulse_sequencer_command_executor_core #(.DDS_CHANNELS(DDS_CH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .in_operation(in_operation),
    .in_timing(in_timing),
    .in_value_a(in_value_a),
    .in_value_b(in_value_b),
    .in_gap_ns(in_gap_ns),
    .empty(empty),
    .pop(pop),
    .out_error(out_error),
    .out_readback_valid(out_readback_valid),
    .out_readback_value(out_readback_value),
    .out_duration_cycles(out_duration_cycles),
    .out_ttl_state(out_ttl_state),
    .out_clock_divider(out_clock_divider),
    .out_timing_ok(out_timing_ok),
    .out_instruction_count(out_instruction_count),
    .out_instruction_cycles(out_instruction_cycles),
    .out_underflow_cycles(out_underflow_cycles)
  );

  always #5 clk = ~clk;

  // Sample every transfer on the edge, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_duration(cfg_index, cfg_data);
      if (push && !full)
        sb.note_command('{op: in_operation, timing: in_timing, va: in_value_a,
                          vb: in_value_b, gap: in_gap_ns});
      if (pop && !empty)
        sb.check_result('{error: pls_pkg::err_t'(out_error),
                          rb_valid: out_readback_valid,
                          rb_value: out_readback_value, duration: out_duration_cycles,
                          ttl: out_ttl_state, clk_div: out_clock_divider,
                          timing_ok: out_timing_ok, count: out_instruction_count,
                          cycles: out_instruction_cycles,
                          underflow: out_underflow_cycles});
    end
  end

  // Result side: pop stays high except for random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) pop <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
      pop <= 1'b0;
      stall_left = $urandom_range(1, 7);
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic sequencer_cmd_t cmd_of(input logic [OPW-1:0] op, input logic timing,
                                            input logic [31:0] va, input logic [31:0] vb,
                                            input logic [31:0] gap);
    sequencer_cmd_t c;
    c.op = op;
    c.timing = timing;
    c.va = va;
    c.vb = vb;
    c.gap = gap;
    return c;
  endfunction

  function automatic sequencer_cmd_t random_command();
    sequencer_cmd_t c;
    int pick;
    c.timing = 1'($urandom_range(0, 1));
    c.vb = $urandom;
    if ($urandom_range(0, 99) < 4)
      c.op = OPW'($urandom_range(32'(OP_FIRST_BAD), 32'(OP_TOP)));
    else c.op = OPW'($urandom_range(0, 32'(pls_pkg::OP_LAST)));

    pick = $urandom_range(0, 99);
    if (sequencer_scoreboard::dds_op(c.op)) begin
      // A few low channels get most of the traffic so that reads hit written entries.
      if (pick < 6) begin
        c.va = $urandom;
        if (c.va < DDS_CH) c.va += DDS_CH;
      end else if (pick < 55) begin
        c.va = $urandom_range(0, 3);
      end else begin
        c.va = $urandom_range(0, DDS_CH - 1);
      end
    end else begin
      c.va = (pick < 25) ? $urandom : $urandom_range(0, 200);
    end

    pick = $urandom_range(0, 99);
    if (pick < 60) c.gap = '0;
    else if (pick < 80) c.gap = $urandom_range(1, 30);
    else if (pick < 95) c.gap = $urandom_range(0, 10000);
    else c.gap = $urandom;
    return c;
  endfunction

  task automatic send_command(input sequencer_cmd_t c);
    if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
      push <= 1'b0;
      in_operation <= OPW'($urandom);
      in_timing <= 1'($urandom);
      in_value_a <= $urandom;
      in_value_b <= $urandom;
      in_gap_ns <= $urandom;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push <= 1'b1;
    in_operation <= c.op;
    in_timing <= c.timing;
    in_value_a <= c.va;
    in_value_b <= c.vb;
    in_gap_ns <= c.gap;
    do @(posedge clk); while (full);
  endtask

  // Stop pushing and wait until every command has come back out.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_durations(input logic [CFGW-1:0] vals [NCFG]);
    for (int i = 0; i < NCFG; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= IDXW'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [CFGW-1:0] vals [NCFG];
    int pick;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the reset durations.
    send_command(cmd_of(pls_pkg::OP_TTL, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0));
    send_command(cmd_of(pls_pkg::OP_CLOCK, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd1));
    send_command(cmd_of(pls_pkg::OP_DAC, 1'b0, 32'd7, 32'd0, 32'hFFFF_FFFF));
    send_command(cmd_of(pls_pkg::OP_WAIT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5));
    send_command(cmd_of(pls_pkg::OP_CLEAR_ERR, 1'b1, 32'd0, 32'd0, 32'd0));
    send_command(cmd_of(pls_pkg::OP_SET_FREQ, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd10));
    send_command(cmd_of(pls_pkg::OP_SET_AMP, 1'b0, DDS_CH - 1, 32'hFFFF_FFFF, 32'd0));
    send_command(cmd_of(pls_pkg::OP_SET_PHASE, 1'b0, DDS_CH - 1, 32'h1234_ABCD, 32'd0));
    send_command(cmd_of(pls_pkg::OP_GET_FREQ, 1'b0, 32'd0, 32'd0, 32'd0));
    send_command(cmd_of(pls_pkg::OP_GET_AMP, 1'b0, DDS_CH - 1, 32'd0, 32'd0));
    send_command(cmd_of(pls_pkg::OP_GET_PHASE, 1'b0, DDS_CH - 1, 32'd0, 32'd0));
    send_command(cmd_of(pls_pkg::OP_DDS_RESET, 1'b0, DDS_CH - 1, 32'd0, 32'd0));
    send_command(cmd_of(pls_pkg::OP_GET_AMP, 1'b0, DDS_CH - 1, 32'd0, 32'd0));
    send_command(cmd_of(pls_pkg::OP_LOOPBACK, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0));
    send_command(cmd_of(pls_pkg::OP_LOOPBACK, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0));
    // An armed check must survive rejected commands and fire on the next valid one.
    send_command(cmd_of(pls_pkg::OP_TTL, 1'b1, 32'd3, 32'h5A5A_A5A5, 32'd0));
    send_command(cmd_of(OP_FIRST_BAD, 1'b1, 32'd1, 32'd1, 32'd100));
    send_command(cmd_of(OP_TOP, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_command(cmd_of(pls_pkg::OP_SET_FREQ, 1'b0, DDS_CH, 32'h1, 32'd50));
    send_command(cmd_of(pls_pkg::OP_GET_PHASE, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd50));
    send_command(cmd_of(pls_pkg::OP_WAIT, 1'b1, 32'd0, 32'd0, 32'd20));
    send_command(cmd_of(pls_pkg::OP_GET_FREQ, 1'b0, DDS_CH - 1, 32'd0, 32'd0));
    send_command(cmd_of(pls_pkg::OP_CLEAR_ERR, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < NCFG; i++) begin
        pick = $urandom_range(0, 9);
        unique case (p)
          0: vals[i] = {CFGW{1'b1}};
          1: vals[i] = '0;
          2: vals[i] = CFGW'(1);
          default: vals[i] = (pick == 0) ? '0 : (pick == 1) ? {CFGW{1'b1}} :
                             CFGW'($urandom_range(1, (1 << CFGW) - 1));
        endcase
      end
      program_durations(vals);
      in_idle_pct = (p == 3) ? 0 : $urandom_range(5, 40);
      out_stall_pct = (p == 4) ? 0 : $urandom_range(5, 40);
      quiet = (p == PHASES - 1);
      repeat (PHASE_ITEMS) send_command(random_command());
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
